// ===== sv/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared widths, types and helpers for the swept circle collision test.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int CoordBits  = 24;
  localparam int SizeBits   = 23;
  localparam int MaxSteps   = 64;
  localparam int StepBits   = $clog2(MaxSteps + 1);
  localparam int DiffBits   = CoordBits + 1;
  localparam int DivBits    = CoordBits + 2;
  localparam int RadBits    = SizeBits + 1;
  localparam int SqBits     = 2 * RadBits;
  localparam int InBits     = 8 * CoordBits + 4 * SizeBits;
  localparam int InBytes    = (InBits + 7) / 8;
  localparam int OutBytes   = 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [SizeBits-1:0]  size_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic        [DivBits-1:0]   div_word_t;

  function automatic diff_t sub_ext(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = diff_t'({a[CoordBits-1], a});
    eb = diff_t'({b[CoordBits-1], b});
    return ea - eb;
  endfunction

  function automatic logic [DiffBits-1:0] mag_diff(diff_t v);
    logic [DiffBits-1:0] n;
    n = DiffBits'(-v);
    return v[DiffBits-1] ? n : DiffBits'(v);
  endfunction

endpackage

// ===== sv/scs_div.sv =====
// ----------------------------------------------------------------------------
// scs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scs_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  scs_pkg::div_word_t   dividend_i,
  input  scs_pkg::div_word_t   divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output scs_pkg::div_word_t   quo_o,
  output scs_pkg::div_word_t   rem_o
);

  localparam int W       = scs_pkg::DivBits;
  localparam int CntBits = $clog2(W + 1);

  logic [W-1:0]       quo_q;
  logic [W-1:0]       rem_q;
  logic [W-1:0]       dvs_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [W:0]   rem_sh;
  logic         ge;
  logic [W:0]   rem_sub;
  logic [W-1:0] rem_d;

  always_comb begin
    rem_sh  = {rem_q, quo_q[W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    rem_d   = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/swept_circle_collision_test_core.sv =====
// The result is ready early when the radius sum is zero, the circles overlap now or the
// motion is small; otherwise the core runs five passes of the 26-step serial divider, then
// works through the n steps (at most 64) on the shared 24x24 multiplier.
// One item at a time; input is taken only when idle, and a stalled output holds the core.
// Reset: rst_ni clears the sequencer and the output valid; no memory to clear.
// ----------------------------------------------------------------------------
// swept_circle_collision_test_core
// Swept circle-circle hit test on a shared multiplier and serial divider.
// ----------------------------------------------------------------------------
module swept_circle_collision_test_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // self_pos_x, self_pos_y, self_prev_x, self_prev_y, self_width, self_height,
  // other_pos_x, other_pos_y, other_prev_x, other_prev_y, other_width, other_height
  input  logic [8*scs_pkg::InBytes-1:0]      s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // hit, steps_capped
  output logic [8*scs_pkg::OutBytes-1:0]     m_axis_tdata_o
);

  localparam int CB = scs_pkg::CoordBits;
  localparam int SB = scs_pkg::SizeBits;
  localparam int DB = scs_pkg::DiffBits;
  localparam int VB = scs_pkg::DivBits;
  localparam int RB = scs_pkg::RadBits;
  localparam int QB = scs_pkg::SqBits;
  localparam int NB = scs_pkg::StepBits;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RAD   = 4'd1;
  localparam logic [3:0] S_RSQ   = 4'd2;
  localparam logic [3:0] S_RSQW  = 4'd3;
  localparam logic [3:0] S_T0    = 4'd4;
  localparam logic [3:0] S_T1    = 4'd5;
  localparam logic [3:0] S_T2    = 4'd6;
  localparam logic [3:0] S_DSTEP = 4'd7;
  localparam logic [3:0] S_DWAIT = 4'd8;
  localparam logic [3:0] S_DAX   = 4'd9;
  localparam logic [3:0] S_DAXW  = 4'd10;
  localparam logic [3:0] S_STEP  = 4'd11;
  localparam logic [3:0] S_POS   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       phase_q;
  logic       hit_q;
  logic       cap_q;
  logic [1:0] k_q;
  logic [NB-1:0] step_q;
  logic       m_valid_q;
  logic [1:0] m_data_q;

  scs_pkg::coord_t cur_q  [4];
  scs_pkg::coord_t prev_q [4];
  scs_pkg::size_t  w1_q, h1_q, w2_q, h2_q;
  logic [RB-1:0]   r2_q;
  logic [QB-1:0]   rsq_q;
  logic [QB-1:0]   acc_q;
  logic [QB-1:0]   mul_q;
  scs_pkg::diff_t  tdx_q, tdy_q;
  logic [NB-1:0]   n_q;
  logic [DB-1:0]   qa_q  [4];
  logic [NB-1:0]   rb_q  [4];
  logic [DB-1:0]   aq_q  [4];
  logic [NB-1:0]   ar_q  [4];

  logic s_accept;
  assign s_accept = s_axis_tvalid_i && (state_q == S_IDLE);

  // displacements and motion
  scs_pkg::diff_t    d     [4];
  logic signed [DB:0] msx, msy;
  logic [VB-1:0]     mx, my, mm, two_m, r2_ext;
  logic              motion_big;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      d[k] = scs_pkg::sub_ext(cur_q[k], prev_q[k]);
    end
    msx    = $signed({d[0][DB-1], d[0]}) + $signed({d[2][DB-1], d[2]});
    msy    = $signed({d[1][DB-1], d[1]}) + $signed({d[3][DB-1], d[3]});
    mx     = msx[DB] ? VB'(-msx) : VB'(msx);
    my     = msy[DB] ? VB'(-msy) : VB'(msy);
    r2_ext = VB'(r2_q);
    motion_big = ({mx[VB-2:0], 1'b0} >= r2_ext) || ({my[VB-2:0], 1'b0} >= r2_ext);
    mm     = (mx > my) ? mx : my;
    two_m  = {mm[VB-2:0], 1'b0};
  end

  // distance test operands
  logic [DB-1:0] abx, aby;
  logic [DB:0]   ax, ay;
  logic          reject;
  logic [QB:0]   sq_sum;
  logic          in_circle;

  always_comb begin
    abx       = scs_pkg::mag_diff(tdx_q);
    aby       = scs_pkg::mag_diff(tdy_q);
    ax        = {abx, 1'b0};
    ay        = {aby, 1'b0};
    reject    = (ax >= (DB+1)'(r2_q)) || (ay >= (DB+1)'(r2_q));
    sq_sum    = {1'b0, acc_q} + {1'b0, mul_q};
    in_circle = sq_sum < {1'b0, rsq_q};
  end

  // shared multiplier
  logic [RB-1:0] mul_a;
  always_comb begin
    if (state_q == S_T0) begin
      mul_a = ax[RB-1:0];
    end else if (state_q == S_T1) begin
      mul_a = ay[RB-1:0];
    end else begin
      mul_a = r2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_a;
  end

  // shared divider
  logic                 div_start;
  scs_pkg::div_word_t   div_num, div_den, div_quo, div_rem;
  logic                 div_busy, div_done;
  logic [DB-1:0]        dmag;

  always_comb begin
    dmag      = scs_pkg::mag_diff(d[k_q]);
    div_start = (state_q == S_DSTEP) || (state_q == S_DAX);
    if (state_q == S_DSTEP) begin
      div_num = two_m;
      div_den = r2_ext;
    end else begin
      div_num = VB'(dmag);
      div_den = VB'(n_q);
    end
  end

  scs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  logic steps_over;
  assign steps_over = div_quo >= VB'(scs_pkg::MaxSteps);

  // per-step accumulation
  logic [NB:0]   rsum [4];
  logic          wrap [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsum[k] = {1'b0, ar_q[k]} + {1'b0, rb_q[k]};
      wrap[k] = rsum[k] >= {1'b0, n_q};
    end
  end

  // interpolated positions
  logic signed [DB+1:0] ip [4];
  logic signed [DB+1:0] ddx, ddy;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ip[k] = $signed({{3{prev_q[k][CB-1]}}, prev_q[k]})
            + (d[k][DB-1] ? -$signed({2'b00, aq_q[k]}) : $signed({2'b00, aq_q[k]}));
    end
    ddx = ip[0] - ip[2];
    ddy = ip[1] - ip[3];
  end

  logic [3:0] fail_next;
  always_comb begin
    if (!phase_q) begin
      fail_next = motion_big ? S_DSTEP : S_DONE;
    end else begin
      fail_next = (step_q == n_q) ? S_DONE : S_STEP;
    end
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_accept) state_d = S_RAD;
      S_RAD:   state_d = S_RSQ;
      S_RSQ:   state_d = (r2_q == '0) ? S_DONE : S_RSQW;
      S_RSQW:  state_d = S_T0;
      S_T0:    state_d = reject ? fail_next : S_T1;
      S_T1:    state_d = S_T2;
      S_T2:    state_d = in_circle ? S_DONE : fail_next;
      S_DSTEP: state_d = S_DWAIT;
      S_DWAIT: if (div_done) state_d = S_DAX;
      S_DAX:   state_d = S_DAXW;
      S_DAXW:  if (div_done) state_d = (k_q == 2'd3) ? S_STEP : S_DAX;
      S_STEP:  state_d = S_POS;
      S_POS:   state_d = S_T0;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= 1'b0;
      hit_q     <= 1'b0;
      cap_q     <= 1'b0;
      k_q       <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            phase_q <= 1'b0;
            hit_q   <= 1'b0;
            cap_q   <= 1'b0;
          end
        end
        S_T2:    if (in_circle) hit_q <= 1'b1;
        S_DWAIT: begin
          if (div_done) begin
            cap_q  <= steps_over;
            k_q    <= '0;
            step_q <= '0;
          end
        end
        S_DAXW:  if (div_done) k_q <= k_q + 1'b1;
        S_STEP:  step_q <= step_q + 1'b1;
        S_POS:   phase_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cur_q[0]  <= s_axis_tdata_i[0*CB +: CB];
      cur_q[1]  <= s_axis_tdata_i[1*CB +: CB];
      prev_q[0] <= s_axis_tdata_i[2*CB +: CB];
      prev_q[1] <= s_axis_tdata_i[3*CB +: CB];
      w1_q      <= s_axis_tdata_i[4*CB +: SB];
      h1_q      <= s_axis_tdata_i[4*CB + SB +: SB];
      cur_q[2]  <= s_axis_tdata_i[4*CB + 2*SB +: CB];
      cur_q[3]  <= s_axis_tdata_i[5*CB + 2*SB +: CB];
      prev_q[2] <= s_axis_tdata_i[6*CB + 2*SB +: CB];
      prev_q[3] <= s_axis_tdata_i[7*CB + 2*SB +: CB];
      w2_q      <= s_axis_tdata_i[8*CB + 2*SB +: SB];
      h2_q      <= s_axis_tdata_i[8*CB + 3*SB +: SB];
    end
    if (state_q == S_RAD) begin
      r2_q  <= {1'b0, (w1_q > h1_q) ? w1_q : h1_q} + {1'b0, (w2_q > h2_q) ? w2_q : h2_q};
      tdx_q <= scs_pkg::sub_ext(cur_q[0], cur_q[2]);
      tdy_q <= scs_pkg::sub_ext(cur_q[1], cur_q[3]);
    end
    if (state_q == S_RSQW) rsq_q <= mul_q;
    if (state_q == S_T1)   acc_q <= mul_q;
    if (state_q == S_DWAIT && div_done) begin
      n_q <= steps_over ? NB'(scs_pkg::MaxSteps) : div_quo[NB-1:0] + 1'b1;
    end
    if (state_q == S_DAXW && div_done) begin
      qa_q[k_q] <= div_quo[DB-1:0];
      rb_q[k_q] <= div_rem[NB-1:0];
      aq_q[k_q] <= '0;
      ar_q[k_q] <= '0;
    end
    if (state_q == S_STEP) begin
      for (int k = 0; k < 4; k++) begin
        ar_q[k] <= wrap[k] ? NB'(rsum[k] - {1'b0, n_q}) : rsum[k][NB-1:0];
        aq_q[k] <= aq_q[k] + qa_q[k] + DB'(wrap[k]);
      end
    end
    if (state_q == S_POS) begin
      tdx_q <= ddx[DB-1:0];
      tdy_q <= ddy[DB-1:0];
    end
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {cap_q, hit_q};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(8*scs_pkg::OutBytes-2){1'b0}}, m_data_q};

`ifndef ASSERT_OFF
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (step_q < n_q))
    else $error("step count ran past the subdivision count");

  a_rem_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POS) |-> (ar_q[0] < n_q && ar_q[1] < n_q && ar_q[2] < n_q && ar_q[3] < n_q))
    else $error("interpolation remainder not below step count");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWAIT || state_q == S_DAXW) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");
`endif

endmodule
